// ----- design/pia_pkg.sv -----
// ----------------------------------------------------------------------------
// pia_pkg: shared types and constants for the padded integer to ASCII block
// Holds the configuration record, the queued item format, register indexes
// and the character helpers used by the back half.
// ----------------------------------------------------------------------------
package pia_pkg;

  localparam int NUM_W        = 64;
  localparam int BYTE_W       = 8;
  localparam int LEN_W        = 7;
  localparam int CFG_INDEX_W  = 3;
  localparam int CFG_DATA_W   = 8;
  localparam int STORE_DEPTH  = 22;
  localparam int POS_W        = 5;
  localparam int DIGIT_W      = 4;
  localparam int BCD_DIGITS   = 20;
  localparam int DABBLE_BITS  = 4;
  localparam int DABBLE_STEPS = NUM_W / DABBLE_BITS;
  localparam int STEP_W       = $clog2(DABBLE_STEPS);
  localparam int QUEUE_DEPTH  = 2;
  localparam int DEFAULT_MAX_FIELD = 64;

  localparam logic [BYTE_W-1:0] CHAR_ZERO    = 8'h30;
  localparam logic [BYTE_W-1:0] CHAR_A_LOWER = 8'h61;
  localparam logic [BYTE_W-1:0] CHAR_MINUS   = 8'h2d;
  localparam logic [BYTE_W-1:0] CHAR_SPACE   = 8'h20;

  localparam logic [CFG_INDEX_W-1:0] CFG_MIN_WIDTH    = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_PAD_BYTE     = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] CFG_RADIX_SELECT = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] CFG_SIGNED_MODE  = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] CFG_WIDE_MODE    = 3'd4;

  localparam logic [1:0] RADIX_DEC = 2'd0;
  localparam logic [1:0] RADIX_HEX = 2'd1;
  localparam logic [1:0] RADIX_OCT = 2'd2;

  typedef enum logic [1:0] {
    KIND_DEC,
    KIND_HEX,
    KIND_OCT
  } kind_t;

  typedef struct packed {
    logic [LEN_W-1:0]  min_width;
    logic [BYTE_W-1:0] pad_byte;
    logic [1:0]        radix_select;
    logic              signed_mode;
    logic              wide_mode;
  } cfg_t;

  typedef struct packed {
    logic [NUM_W-1:0] magnitude;
    kind_t            kind;
    logic             negative;
  } item_t;

  function automatic logic [BYTE_W-1:0] digit_char(input logic [DIGIT_W-1:0] d);
    logic [BYTE_W-1:0] c;
    if (d < 4'd10) begin
      c = CHAR_ZERO + BYTE_W'(d);
    end else begin
      c = CHAR_A_LOWER + BYTE_W'(d - 4'd10);
    end
    return c;
  endfunction

endpackage

// ----- design/pia_front.sv -----
// ----------------------------------------------------------------------------
// pia_front: input classification
// Masks the number to the selected word size, picks the base and takes the
// magnitude of a negative signed decimal value before it enters the queue.
// ----------------------------------------------------------------------------
module pia_front (
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [63:0]           number,
  input  pia_pkg::cfg_t         cfg,
  input  logic                  queue_full,
  output logic                  push,
  output pia_pkg::item_t        push_item
);
  import pia_pkg::*;

  logic [NUM_W-1:0] masked;
  logic [NUM_W-1:0] negated;
  logic             sign_bit;
  logic             is_neg;
  kind_t            kind;

  assign in_ready = !queue_full;
  assign push     = in_valid && !queue_full;

  always_comb begin
    masked   = cfg.wide_mode ? number : {32'b0, number[31:0]};
    negated  = NUM_W'(0) - masked;
    sign_bit = cfg.wide_mode ? number[63] : number[31];
    priority if (cfg.radix_select == RADIX_HEX) begin
      kind = KIND_HEX;
    end else if (cfg.radix_select == RADIX_OCT) begin
      kind = KIND_OCT;
    end else begin
      kind = KIND_DEC;
    end
    is_neg = (kind == KIND_DEC) && cfg.signed_mode && sign_bit;
    push_item.kind     = kind;
    push_item.negative = is_neg;
    if (!is_neg) begin
      push_item.magnitude = masked;
    end else if (cfg.wide_mode) begin
      push_item.magnitude = negated;
    end else begin
      push_item.magnitude = {32'b0, negated[31:0]};
    end
  end

endmodule

// ----- design/pia_queue.sv -----
// ----------------------------------------------------------------------------
// pia_queue: short item queue
// A small FIFO between the classifier and the formatter so that the classifier
// can go on taking items while the formatter is busy, until the FIFO is full.
// ----------------------------------------------------------------------------
module pia_queue #(
  parameter int DEPTH = pia_pkg::QUEUE_DEPTH
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  pia_pkg::item_t push_item,
  output logic           full,
  input  logic           pop,
  output pia_pkg::item_t pop_item,
  output logic           not_empty
);
  import pia_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  item_t            entries [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_push;
  logic             do_pop;

  assign full      = (count == CNT_W'(DEPTH));
  assign not_empty = (count != '0);
  assign pop_item  = entries[rd_ptr];
  assign do_push   = push && !full;
  assign do_pop    = pop && not_empty;

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

// ----- design/pia_back.sv -----
// ----------------------------------------------------------------------------
// pia_back: digit generation and character output
// Builds the digit store (double dabble for decimal, direct slices for hex
// and octal), sizes the field and sends it out one character per output transfer.
// ----------------------------------------------------------------------------
module pia_back #(
  parameter int MAX_FIELD = pia_pkg::DEFAULT_MAX_FIELD
) (
  input  logic           clk,
  input  logic           rst,
  input  pia_pkg::cfg_t  cfg,
  input  logic           q_valid,
  input  pia_pkg::item_t q_item,
  output logic           q_pop,
  output logic           out_valid,
  input  logic           out_ready,
  output logic [7:0]     text_byte,
  output logic           final_char,
  output logic [6:0]     field_length
);
  import pia_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CONV,
    ST_SIZE,
    ST_EMIT
  } state_t;

  state_t                               state;
  logic [NUM_W-1:0]                     shift_value;
  logic [STEP_W-1:0]                    step_cnt;
  logic [STORE_DEPTH-1:0][DIGIT_W-1:0]  digit_store;
  logic                                 negative_flag;
  logic [POS_W-1:0]                     len;
  logic [LEN_W-1:0]                     width;
  logic [LEN_W-1:0]                     remaining;

  logic [BCD_DIGITS*DIGIT_W-1:0]        bcd_next;
  logic [STORE_DEPTH-1:0][DIGIT_W-1:0]  slice_digits;
  logic [STORE_DEPTH*DIGIT_W-1:0]       hex_padded;
  logic [NUM_W+1:0]                     oct_padded;
  logic [POS_W-1:0]                     ndig;
  logic [POS_W-1:0]                     len_next;
  logic [LEN_W-1:0]                     sat_width;
  logic [LEN_W-1:0]                     width_next;
  logic [POS_W-1:0]                     pos;
  logic [BYTE_W-1:0]                    char_next;
  logic                                 out_free;

  assign q_pop    = (state == ST_IDLE) && q_valid;
  assign out_free = !out_valid || out_ready;

  // Four shift-and-correct steps of the binary to BCD conversion per cycle.
  always_comb begin
    bcd_next = digit_store[BCD_DIGITS-1:0];
    for (int s = 0; s < DABBLE_BITS; s++) begin
      for (int d = 0; d < BCD_DIGITS; d++) begin
        if (bcd_next[d*DIGIT_W +: DIGIT_W] >= 4'd5) begin
          bcd_next[d*DIGIT_W +: DIGIT_W] = bcd_next[d*DIGIT_W +: DIGIT_W] + 4'd3;
        end
      end
      bcd_next = {bcd_next[BCD_DIGITS*DIGIT_W-2:0], shift_value[NUM_W-1-s]};
    end
  end

  always_comb begin
    hex_padded = {{(STORE_DEPTH*DIGIT_W-NUM_W){1'b0}}, q_item.magnitude};
    oct_padded = {2'b0, q_item.magnitude};
    for (int i = 0; i < STORE_DEPTH; i++) begin
      if (q_item.kind == KIND_HEX) begin
        slice_digits[i] = hex_padded[i*DIGIT_W +: DIGIT_W];
      end else begin
        slice_digits[i] = {1'b0, oct_padded[i*3 +: 3]};
      end
    end
  end

  // Field sizing: highest nonzero digit, sign, then the configured width.
  always_comb begin
    ndig = POS_W'(1);
    for (int i = 1; i < STORE_DEPTH; i++) begin
      if (digit_store[i] != '0) begin
        ndig = POS_W'(i + 1);
      end
    end
    len_next  = ndig + POS_W'(negative_flag);
    sat_width = (cfg.min_width > LEN_W'(MAX_FIELD)) ? LEN_W'(MAX_FIELD) : cfg.min_width;
    width_next = (sat_width < LEN_W'(len_next)) ? LEN_W'(len_next) : sat_width;
  end

  always_comb begin
    pos = remaining[POS_W-1:0] - POS_W'(1);
    priority if (remaining > LEN_W'(len)) begin
      char_next = cfg.pad_byte;
    end else if (negative_flag && remaining[POS_W-1:0] == len) begin
      char_next = CHAR_MINUS;
    end else begin
      char_next = digit_char(digit_store[pos]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      out_valid     <= 1'b0;
      negative_flag <= 1'b0;
      remaining     <= '0;
      step_cnt      <= '0;
    end else begin
      if (state == ST_EMIT && out_free) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (q_valid) begin
            shift_value   <= q_item.magnitude;
            negative_flag <= q_item.negative;
            step_cnt      <= '0;
            if (q_item.kind == KIND_DEC) begin
              digit_store <= '0;
              state       <= ST_CONV;
            end else begin
              digit_store <= slice_digits;
              state       <= ST_SIZE;
            end
          end
        end
        ST_CONV: begin
          digit_store <= {{((STORE_DEPTH - BCD_DIGITS)*DIGIT_W){1'b0}}, bcd_next};
          shift_value <= shift_value << DABBLE_BITS;
          step_cnt    <= step_cnt + 1'b1;
          if (step_cnt == STEP_W'(DABBLE_STEPS - 1)) begin
            state <= ST_SIZE;
          end
        end
        ST_SIZE: begin
          len       <= len_next;
          width     <= width_next;
          remaining <= width_next;
          state     <= ST_EMIT;
        end
        ST_EMIT: begin
          if (out_free) begin
            text_byte    <= char_next;
            final_char   <= (remaining == LEN_W'(1));
            field_length <= width;
            remaining    <= remaining - 1'b1;
            if (remaining == LEN_W'(1)) begin
              state <= ST_IDLE;
            end
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

// ----- design/padded_integer_to_ascii.sv -----
// ----------------------------------------------------------------------------
// padded_integer_to_ascii: integer to padded ASCII text formatter
// Turns each input item into a decimal, hex or octal character field,
// padded on the left to a configured minimum width.
// ----------------------------------------------------------------------------
// Flow: hex and octal digits are sliced straight from the item into the
// digit store; decimal goes through 4-bit-per-cycle BCD conversion first. The
// field is then sized and sent out one character a cycle while out_ready
// allows; the formatter takes its next item only after the last character, and
// a two-item queue lets input be taken during that time.
// Reset: synchronous; clears control state and loads the register defaults.
module padded_integer_to_ascii #(
  parameter int MAX_FIELD = pia_pkg::DEFAULT_MAX_FIELD
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic [63:0]                      number,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic [7:0]                       text_byte,
  output logic                             final_char,
  output logic [6:0]                       field_length,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [pia_pkg::CFG_INDEX_W-1:0]  cfg_index,
  input  logic [pia_pkg::CFG_DATA_W-1:0]   cfg_data
);
  import pia_pkg::*;

  cfg_t  cfg;
  logic  queue_full;
  logic  push;
  item_t push_item;
  logic  q_pop;
  item_t q_item;
  logic  q_valid;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.min_width    <= '0;
      cfg.pad_byte     <= CHAR_SPACE;
      cfg.radix_select <= RADIX_DEC;
      cfg.signed_mode  <= 1'b0;
      cfg.wide_mode    <= 1'b1;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_MIN_WIDTH:    cfg.min_width    <= cfg_data[LEN_W-1:0];
        CFG_PAD_BYTE:     cfg.pad_byte     <= cfg_data;
        CFG_RADIX_SELECT: cfg.radix_select <= cfg_data[1:0];
        CFG_SIGNED_MODE:  cfg.signed_mode  <= cfg_data[0];
        CFG_WIDE_MODE:    cfg.wide_mode    <= cfg_data[0];
        default: begin
        end
      endcase
    end
  end

  pia_front u_front (
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .number     (number),
    .cfg        (cfg),
    .queue_full (queue_full),
    .push       (push),
    .push_item  (push_item)
  );

  pia_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_item (push_item),
    .full      (queue_full),
    .pop       (q_pop),
    .pop_item  (q_item),
    .not_empty (q_valid)
  );

  pia_back #(
    .MAX_FIELD (MAX_FIELD)
  ) u_back (
    .clk          (clk),
    .rst          (rst),
    .cfg          (cfg),
    .q_valid      (q_valid),
    .q_item       (q_item),
    .q_pop        (q_pop),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .text_byte    (text_byte),
    .final_char   (final_char),
    .field_length (field_length)
  );

endmodule

// ----- dv/padded_integer_to_ascii_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// padded_integer_to_ascii_tb: self-checking bench for the ASCII formatter
// Programs the format registers between phases, feeds integers through the
// input channel and compares every emitted character, its last flag and the
// field length against a field predicted inside the bench. A directed set of
// corner cases comes first, then randomized phases with random flow control.
// ----------------------------------------------------------------------------
module padded_integer_to_ascii_tb;
  import pia_pkg::*;

  localparam int          FIELD_LIMIT    = 64;
  localparam int          DIGIT_SLOTS    = 22;
  localparam int          RANDOM_PHASES  = 10;
  localparam int          PHASE_ITEMS    = 30;
  localparam int          LONG_HOLD      = 300;
  localparam int          WATCHDOG_LIMIT = 3000;
  localparam int          SETTLE_CYCLES  = 64;
  localparam logic [1:0]  RADIX_UNUSED   = 2'd3;
  localparam string       DIGIT_CHARS    = "0123456789abcdef";

  typedef struct {
    logic [7:0] ch;
    logic       is_last;
    logic [6:0] len;
  } text_char_t;

  class format_scoreboard;
    cfg_t       fmt;
    text_char_t expected_text[$];
    int         mismatches;

    function new();
      fmt.min_width    = '0;
      fmt.pad_byte     = CHAR_SPACE;
      fmt.radix_select = RADIX_DEC;
      fmt.signed_mode  = 1'b0;
      fmt.wide_mode    = 1'b1;
      mismatches       = 0;
    endfunction

    function void write_reg(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        CFG_MIN_WIDTH:    fmt.min_width    = data[LEN_W-1:0];
        CFG_PAD_BYTE:     fmt.pad_byte     = data;
        CFG_RADIX_SELECT: fmt.radix_select = data[1:0];
        CFG_SIGNED_MODE:  fmt.signed_mode  = data[0];
        CFG_WIDE_MODE:    fmt.wide_mode    = data[0];
        default: ;
      endcase
    endfunction

    // Builds the digits least significant first, then lays out the field.
    function void note_number(logic [63:0] value);
      logic [63:0]  mag;
      logic         neg;
      logic [7:0]   digits [DIGIT_SLOTS];
      int unsigned  count;
      int unsigned  width;
      int unsigned  pads;
      text_char_t   entry;

      mag   = fmt.wide_mode ? value : {32'd0, value[31:0]};
      neg   = 1'b0;
      count = 0;
      case (fmt.radix_select)
        RADIX_HEX: begin
          do begin
            digits[count] = DIGIT_CHARS[int'(mag[3:0])];
            count++;
            mag = mag >> 4;
          end while (mag != 0 && count < DIGIT_SLOTS);
        end
        RADIX_OCT: begin
          do begin
            digits[count] = DIGIT_CHARS[int'(mag[2:0])];
            count++;
            mag = mag >> 3;
          end while (mag != 0 && count < DIGIT_SLOTS);
        end
        default: begin
          if (fmt.signed_mode) begin
            if (fmt.wide_mode && mag[63]) begin
              mag = 64'd0 - mag;
              neg = 1'b1;
            end else if (!fmt.wide_mode && mag[31]) begin
              mag = (64'd0 - mag) & 64'h0000_0000_ffff_ffff;
              neg = 1'b1;
            end
          end
          do begin
            digits[count] = DIGIT_CHARS[int'(mag % 64'd10)];
            count++;
            mag = mag / 64'd10;
          end while (mag != 0 && count < DIGIT_SLOTS);
          if (neg && count < DIGIT_SLOTS) begin
            digits[count] = CHAR_MINUS;
            count++;
          end
        end
      endcase

      width = fmt.min_width;
      if (width > FIELD_LIMIT) width = FIELD_LIMIT;
      if (width < count) width = count;
      pads = width - count;
      for (int unsigned k = 0; k < width; k++) begin
        entry.ch      = (k < pads) ? fmt.pad_byte : digits[width - 1 - k];
        entry.is_last = (k + 1 == width);
        entry.len     = LEN_W'(width);
        expected_text.push_back(entry);
      end
    endfunction

    function void check_char(logic [7:0] ch, logic is_last, logic [6:0] len);
      text_char_t want;
      if (expected_text.size() == 0) begin
        $display("%0t: unexpected character %h (last %b, length %0d)", $time, ch, is_last, len);
        mismatches++;
        return;
      end
      want = expected_text.pop_front();
      if (ch !== want.ch) begin
        $display("%0t: text_byte expected %h, got %h", $time, want.ch, ch);
        mismatches++;
      end
      if (is_last !== want.is_last) begin
        $display("%0t: final_char expected %b, got %b", $time, want.is_last, is_last);
        mismatches++;
      end
      if (len !== want.len) begin
        $display("%0t: field_length expected %0d, got %0d", $time, want.len, len);
        mismatches++;
      end
    endfunction

    function int pending();
      return expected_text.size();
    endfunction
  endclass

  logic                   clk;
  logic                   rst;
  logic                   in_valid;
  logic                   in_ready;
  logic [63:0]            number;
  logic                   out_valid;
  logic                   out_ready;
  logic [7:0]             text_byte;
  logic                   final_char;
  logic [6:0]             field_length;
  logic                   cfg_valid;
  logic                   cfg_ready;
  logic [CFG_INDEX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0]  cfg_data;

  format_scoreboard sb = new();
  bit               calm = 1'b0;
  bit               hold_output = 1'b0;
  int               quiet_cycles = 0;

  padded_integer_to_ascii u_dut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .number       (number),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .text_byte    (text_byte),
    .final_char   (final_char),
    .field_length (field_length),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      sb.check_char(text_byte, final_char, field_length);
    end
  end

  // Receiver: random stall bursts, free-running stretches, and one long hold
  // that lets the block fill up and back-pressure its input.
  initial begin
    out_ready = 1'b0;
    while (rst !== 1'b0) @(posedge clk);
    forever begin
      if (hold_output) begin
        out_ready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
        hold_output = 1'b0;
      end else if (!calm && $urandom_range(0, 4) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 17)) @(posedge clk);
      end else if ($urandom_range(0, 9) == 0) begin
        out_ready <= 1'b1;
        repeat ($urandom_range(20, 60)) @(posedge clk);
      end
      out_ready <= 1'b1;
      @(posedge clk);
    end
  end

  initial begin
    while (quiet_cycles < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if (rst || (in_valid && in_ready) || (out_valid && out_ready) ||
          (cfg_valid && cfg_ready)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
    end
    $display("padded_integer_to_ascii_tb: FAIL");
    $finish;
  end

  task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [7:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    sb.write_reg(idx, data);
  endtask

  // Waits until every expected character is out, then reprograms all
  // registers while the block is idle.
  task automatic set_format(input logic [7:0] min_width, input logic [7:0] pad,
                            input logic [1:0] radix, input logic sgn, input logic wide);
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    write_reg(CFG_MIN_WIDTH, min_width);
    write_reg(CFG_PAD_BYTE, pad);
    write_reg(CFG_RADIX_SELECT, {6'd0, radix});
    write_reg(CFG_SIGNED_MODE, {7'd0, sgn});
    write_reg(CFG_WIDE_MODE, {7'd0, wide});
    cfg_valid <= 1'b0;
  endtask

  task automatic offer(input logic [63:0] value);
    if (!calm && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 17)) @(posedge clk);
    end
    in_valid <= 1'b1;
    number   <= value;
    do @(posedge clk); while (!in_ready);
    sb.note_number(value);
  endtask

  function automatic logic [63:0] pick_number();
    logic [31:0] hi;
    logic [31:0] lo;
    logic [63:0] v;
    hi = $urandom;
    lo = $urandom;
    case ($urandom_range(0, 6))
      0: v = {hi, lo};
      1: v = 64'($urandom_range(0, 1000));
      2: v = 64'd0 - 64'($urandom_range(1, 1000));
      3: v = {hi, 32'd0 - 32'($urandom_range(1, 100000))};
      4: v = (64'd1 << $urandom_range(0, 63)) - 64'($urandom_range(0, 1));
      5: v = {hi, lo} >> $urandom_range(1, 63);
      default: v = ($urandom_range(0, 1) != 0) ? 64'h8000_0000_0000_0000
                                               : 64'h0000_0000_8000_0000;
    endcase
    return v;
  endfunction

  initial begin
    logic [7:0] mw;
    rst       = 1'b1;
    in_valid  = 1'b0;
    number    = '0;
    cfg_valid = 1'b0;
    cfg_index = CFG_MIN_WIDTH;
    cfg_data  = '0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // Plain unsigned decimal at natural width.
    set_format(8'd0, CHAR_SPACE, RADIX_DEC, 1'b0, 1'b1);
    offer(64'd0);
    offer(64'd1);
    offer(64'd9);
    offer(64'd10);
    offer(64'hffff_ffff_ffff_ffff);
    offer(64'h8000_0000_0000_0000);

    // Signed decimal: the pad goes before the minus sign.
    set_format(8'd25, 8'h2a, RADIX_DEC, 1'b1, 1'b1);
    offer(64'h8000_0000_0000_0000);
    offer(64'hffff_ffff_ffff_ffff);
    offer(64'd0);
    offer(64'd12345);

    // Hex ignores the sign setting, and zero still prints one digit.
    set_format(8'd0, 8'h00, RADIX_HEX, 1'b1, 1'b1);
    offer(64'd0);
    offer(64'hffff_ffff_ffff_ffff);
    offer(64'h0123_4567_89ab_cdef);

    // Octal on the low 32 bits, padded to the widest field.
    set_format(8'd64, CHAR_ZERO, RADIX_OCT, 1'b0, 1'b0);
    offer(64'd0);
    offer(64'hffff_ffff_ffff_ffff);
    offer(64'hffff_ffff_0000_0008);

    // Unused radix code falls back to decimal; an oversized width saturates.
    set_format(8'd200, 8'hff, RADIX_UNUSED, 1'b1, 1'b0);
    offer(64'h0000_0000_8000_0000);
    offer(64'hffff_ffff_7fff_ffff);
    offer(64'h1234_5678_ffff_ffff);

    // A width below the natural length has no effect; above it, the field is padded.
    set_format(8'd3, 8'h2e, RADIX_OCT, 1'b0, 1'b1);
    offer(64'hffff_ffff_ffff_ffff);
    offer(64'd7);

    for (int p = 0; p < RANDOM_PHASES; p++) begin
      case ($urandom_range(0, 7))
        0: mw = 8'd0;
        1: mw = 8'(FIELD_LIMIT);
        2: mw = 8'($urandom_range(65, 255));
        default: mw = 8'($urandom_range(1, 24));
      endcase
      if (p == 0) mw = 8'd0;
      if (p == 1) mw = 8'(FIELD_LIMIT);
      set_format(mw, 8'($urandom_range(0, 255)), 2'($urandom_range(0, 3)),
                 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
      calm = (p == RANDOM_PHASES - 1);
      if (p == 3) hold_output = 1'b1;
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        offer(pick_number());
      end
    end

    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("padded_integer_to_ascii_tb: PASS");
    end else begin
      $display("padded_integer_to_ascii_tb: FAIL");
    end
    $finish;
  end

endmodule
